>>> design/lkvc_pkg.sv
// Shared constants, payload types and control structs of the LRU key-value cache.
`timescale 1ns / 1ps
`default_nettype none
package lkvc_pkg;

	localparam int DEPTH       = 16;
	localparam int KEY_WIDTH   = 32;
	localparam int VALUE_WIDTH = 32;
	localparam int IDX_WIDTH   = $clog2(DEPTH);
	localparam int COUNT_WIDTH = 5;
	localparam int CAP_WIDTH   = 5;
	localparam int FUNC_WIDTH  = 2;

	localparam int APB_ADDR_WIDTH = 3;
	localparam int APB_DATA_WIDTH = 32;

	localparam logic [CAP_WIDTH-1:0] CAP_RESET = CAP_WIDTH'(16);

	localparam logic [FUNC_WIDTH-1:0] FUNC_PUT    = 2'd0;
	localparam logic [FUNC_WIDTH-1:0] FUNC_GET    = 2'd1;
	localparam logic [FUNC_WIDTH-1:0] FUNC_EXISTS = 2'd2;

	localparam logic [APB_ADDR_WIDTH-1:0] REG_CAPACITY = 3'd0;

	typedef struct packed {
		logic [FUNC_WIDTH-1:0]  func;
		logic [KEY_WIDTH-1:0]   key;
		logic [VALUE_WIDTH-1:0] value_in;
	} req_t;

	typedef struct packed {
		logic                   found;
		logic [VALUE_WIDTH-1:0] value_out;
		logic [COUNT_WIDTH-1:0] count;
	} rsp_t;

	typedef struct packed {
		logic                   found;
		logic                   get_hit;
		logic                   wr_en;
		logic [IDX_WIDTH-1:0]   rd_addr;
		logic [IDX_WIDTH-1:0]   wr_addr;
		logic [COUNT_WIDTH-1:0] count_next;
	} access_t;

endpackage
`default_nettype wire

>>> design/lkvc_ram.sv
// Generic single write port, single read port RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module lkvc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule
`default_nettype wire

>>> design/lkvc_tags.sv
// Key cells, valid bits, recency ranks and entry count with their update logic.
`timescale 1ns / 1ps
`default_nettype none
module lkvc_tags
	import lkvc_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 adv,
	input  wire req_t                 req,
	input  wire logic [CAP_WIDTH-1:0] capacity,
	output access_t                   acc
);

	logic [KEY_WIDTH-1:0]   key_q   [DEPTH];
	logic [IDX_WIDTH-1:0]   rank_q  [DEPTH];
	logic [DEPTH-1:0]       valid_q;
	logic [COUNT_WIDTH-1:0] count_q;

	logic [IDX_WIDTH-1:0]   rank_d  [DEPTH];
	logic [IDX_WIDTH-1:0]   prom_rank [DEPTH];
	logic [IDX_WIDTH-1:0]   cmp_rank  [DEPTH];
	logic [DEPTH-1:0]       valid_d;
	logic [DEPTH-1:0]       valid_ev;
	logic [DEPTH-1:0]       hit_vec;
	logic [DEPTH-1:0]       victim;
	logic [DEPTH-1:0]       ev_vec;
	logic [COUNT_WIDTH-1:0] count_d;
	logic [COUNT_WIDTH-1:0] count_ev;
	logic [COUNT_WIDTH-1:0] cap_eff;
	logic [IDX_WIDTH-1:0]   hit_idx;
	logic [IDX_WIDTH-1:0]   slot;
	logic                   slot_ok;
	logic                   hit;
	logic                   is_put;
	logic                   is_get;
	logic                   is_exists;
	logic                   need_ev;
	logic                   drop_new;
	logic                   do_ins;

	assign is_put    = (req.func == FUNC_PUT);
	assign is_get    = (req.func == FUNC_GET);
	assign is_exists = (req.func == FUNC_EXISTS);

	assign cap_eff = (capacity > COUNT_WIDTH'(DEPTH)) ? COUNT_WIDTH'(DEPTH) : capacity;

	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			hit_vec[i] = valid_q[i] && (key_q[i] == req.key);
		end
		hit = |hit_vec;
		hit_idx = '0;
		for (int i = DEPTH - 1; i >= 0; i--) begin
			if (hit_vec[i]) begin
				hit_idx = IDX_WIDTH'(i);
			end
		end
	end

	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			if (valid_q[i] && (rank_q[i] < rank_q[hit_idx])) begin
				prom_rank[i] = rank_q[i] + IDX_WIDTH'(1);
			end else begin
				prom_rank[i] = rank_q[i];
			end
		end
		prom_rank[hit_idx] = '0;
	end

	always_comb begin
		drop_new = !hit && (count_q >= cap_eff) && (count_q == '0);
		if (hit) begin
			need_ev = count_q > cap_eff;
		end else begin
			need_ev = (count_q >= cap_eff) && (count_q != '0);
		end
		for (int i = 0; i < DEPTH; i++) begin
			cmp_rank[i] = hit ? prom_rank[i] : rank_q[i];
			victim[i] = valid_q[i]
				&& ({{(COUNT_WIDTH-IDX_WIDTH){1'b0}}, cmp_rank[i]} == count_q - COUNT_WIDTH'(1));
		end
		ev_vec   = need_ev ? victim : '0;
		valid_ev = valid_q & ~ev_vec;
		count_ev = count_q - COUNT_WIDTH'(|ev_vec);
		slot     = '0;
		slot_ok  = 1'b0;
		for (int i = DEPTH - 1; i >= 0; i--) begin
			if (!valid_ev[i]) begin
				slot    = IDX_WIDTH'(i);
				slot_ok = 1'b1;
			end
		end
		do_ins = is_put && !hit && !drop_new && slot_ok;
	end

	always_comb begin
		valid_d = valid_q;
		count_d = count_q;
		for (int i = 0; i < DEPTH; i++) begin
			rank_d[i] = rank_q[i];
		end
		if (is_get && hit) begin
			for (int i = 0; i < DEPTH; i++) begin
				rank_d[i] = prom_rank[i];
			end
		end else if (is_put && hit) begin
			for (int i = 0; i < DEPTH; i++) begin
				rank_d[i] = prom_rank[i];
			end
			valid_d = valid_ev;
			count_d = count_ev;
		end else if (is_put && !drop_new) begin
			valid_d = valid_ev;
			count_d = count_ev;
			if (do_ins) begin
				for (int i = 0; i < DEPTH; i++) begin
					if (valid_ev[i]) begin
						rank_d[i] = rank_q[i] + IDX_WIDTH'(1);
					end
				end
				rank_d[slot]  = '0;
				valid_d[slot] = 1'b1;
				count_d       = count_ev + COUNT_WIDTH'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			count_q <= '0;
		end else if (adv) begin
			valid_q <= valid_d;
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < DEPTH; i++) begin
				rank_q[i] <= rank_d[i];
			end
			if (do_ins) begin
				key_q[slot] <= req.key;
			end
		end
	end

	always_comb begin
		acc.found      = (is_get || is_exists) && hit;
		acc.get_hit    = is_get && hit;
		acc.wr_en      = is_put && (hit || do_ins);
		acc.rd_addr    = hit_idx;
		acc.wr_addr    = hit ? hit_idx : slot;
		acc.count_next = count_d;
	end

endmodule
`default_nettype wire

>>> design/lru_key_value_cache_core.sv
// Top level of the fully associative LRU key-value cache.
//
//  channel  direction  handshake              payload
//  req      in         req_valid / req_ready  req_t: func, key, value_in
//  rsp      out        rsp_valid / rsp_ready  rsp_t: found, value_out, count
//  cfg      in         APB, pready tied high  capacity at byte address 0
//
// One item per cycle sustained while the result side does not stall.
// An item sits in the input register, then lookup, rank update and eviction
// complete combinationally into the result register and the value RAM read port.
// A stalled result holds the input register and, with an item there, drops req_ready until taken.
// Reset clears valid bits and entry count and sets capacity to 16; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module lru_key_value_cache_core
	import lkvc_pkg::*;
(
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      psel,
	input  wire logic                      penable,
	input  wire logic                      pwrite,
	input  wire logic [APB_ADDR_WIDTH-1:0] paddr,
	input  wire logic [APB_DATA_WIDTH-1:0] pwdata,
	output logic      [APB_DATA_WIDTH-1:0] prdata,
	output logic                           pready,
	input  wire logic                      req_valid,
	output logic                           req_ready,
	input  wire req_t                      req,
	output logic                           rsp_valid,
	input  wire logic                      rsp_ready,
	output rsp_t                           rsp
);

	logic [CAP_WIDTH-1:0]   capacity_q;
	logic                   valid_s1;
	req_t                   req_s1;
	logic                   rsp_valid_q;
	logic                   found_q;
	logic                   get_hit_q;
	logic [COUNT_WIDTH-1:0] count_q;
	logic [VALUE_WIDTH-1:0] rd_data;
	logic                   adv;
	access_t                acc;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAP_RESET;
		end else if (psel && penable && pwrite && pready && (paddr[2] == REG_CAPACITY[2])) begin
			capacity_q <= pwdata[CAP_WIDTH-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_CAPACITY[2]) begin
			prdata = {{(APB_DATA_WIDTH-CAP_WIDTH){1'b0}}, capacity_q};
		end
	end

	assign adv       = valid_s1 && (!rsp_valid_q || rsp_ready);
	assign req_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_ready) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			req_s1 <= req;
		end
	end

	lkvc_tags u_tags (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.req      (req_s1),
		.capacity (capacity_q),
		.acc      (acc)
	);

	lkvc_ram #(
		.WIDTH (VALUE_WIDTH),
		.DEPTH (DEPTH)
	) u_values (
		.clk     (clk),
		.wr_en   (adv && acc.wr_en),
		.wr_addr (acc.wr_addr),
		.wr_data (req_s1.value_in),
		.rd_en   (adv && acc.get_hit),
		.rd_addr (acc.rd_addr),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (adv) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			found_q   <= acc.found;
			get_hit_q <= acc.get_hit;
			count_q   <= acc.count_next;
		end
	end

	assign rsp_valid     = rsp_valid_q;
	assign rsp.found     = found_q;
	assign rsp.value_out = get_hit_q ? rd_data : '0;
	assign rsp.count     = count_q;

endmodule
`default_nettype wire

>>> design/lkvc_checker.sv
// Port-level assertions for the LRU key-value cache and their bind.
`timescale 1ns / 1ps
`default_nettype none
module lkvc_checker
	import lkvc_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic req_ready,
	input wire logic rsp_valid,
	input wire logic rsp_ready,
	input wire rsp_t rsp
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("result item dropped or changed while stalled");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!rsp_valid |-> req_ready)
		else $error("request refused with no result pending");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp.count <= COUNT_WIDTH'(DEPTH))
		else $error("entry count above depth");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.found |-> rsp.value_out == '0)
		else $error("value on a result item without a hit");

endmodule

bind lru_key_value_cache_core lkvc_checker u_lkvc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_ready (req_ready),
	.rsp_valid (rsp_valid),
	.rsp_ready (rsp_ready),
	.rsp       (rsp)
);
`default_nettype wire

>>> bench/lkvc_cache_checker.sv
// Checker for the LRU key-value cache: shadow store, queue of expected responses, field compare.
`timescale 1ns / 1ps
`default_nettype none
module lkvc_cache_checker
	import lkvc_pkg::*;
(
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      psel,
	input  wire logic                      penable,
	input  wire logic                      pwrite,
	input  wire logic                      pready,
	input  wire logic [APB_ADDR_WIDTH-1:0] paddr,
	input  wire logic [APB_DATA_WIDTH-1:0] pwdata,
	input  wire logic                      req_valid,
	input  wire logic                      req_ready,
	input  wire req_t                      req,
	input  wire logic                      rsp_valid,
	input  wire logic                      rsp_ready,
	input  wire rsp_t                      rsp,
	output int                             mismatch_count,
	output int                             outstanding,
	output int                             responses_checked,
	output int                             hits_seen
);

	logic [KEY_WIDTH-1:0]   shadow_key   [DEPTH];
	logic [VALUE_WIDTH-1:0] shadow_value [DEPTH];
	logic                   shadow_valid [DEPTH];
	int unsigned            shadow_rank  [DEPTH];
	int unsigned            shadow_count;
	logic [CAP_WIDTH-1:0]   capacity;
	rsp_t                   expected_q [$];
	int                     n_fail;
	int                     n_checked;
	int                     n_hits;

	function automatic int find_key(logic [KEY_WIDTH-1:0] k);
		for (int i = 0; i < DEPTH; i++) begin
			if (shadow_valid[i] && shadow_key[i] == k) return i;
		end
		return -1;
	endfunction

	function automatic void promote(int slot);
		int unsigned r;
		r = shadow_rank[slot];
		for (int i = 0; i < DEPTH; i++) begin
			if (shadow_valid[i] && shadow_rank[i] < r) shadow_rank[i]++;
		end
		shadow_rank[slot] = 0;
	endfunction

	function automatic void drop_oldest();
		if (shadow_count == 0) return;
		for (int i = 0; i < DEPTH; i++) begin
			if (shadow_valid[i] && shadow_rank[i] == shadow_count - 1) begin
				shadow_valid[i] = 1'b0;
				shadow_count--;
				return;
			end
		end
	endfunction

	function automatic void store(logic [KEY_WIDTH-1:0] k, logic [VALUE_WIDTH-1:0] v);
		int unsigned limit;
		int slot;
		limit = (capacity > DEPTH) ? DEPTH : capacity;
		slot = find_key(k);
		if (slot >= 0) begin
			shadow_value[slot] = v;
			promote(slot);
			if (shadow_count > limit) drop_oldest();
			return;
		end
		if (shadow_count + 1 > limit) begin
			if (shadow_count == 0) return;
			drop_oldest();
		end
		for (int i = 0; i < DEPTH; i++) begin
			if (!shadow_valid[i]) begin
				for (int j = 0; j < DEPTH; j++) begin
					if (shadow_valid[j]) shadow_rank[j]++;
				end
				shadow_valid[i] = 1'b1;
				shadow_key[i]   = k;
				shadow_value[i] = v;
				shadow_rank[i]  = 0;
				shadow_count++;
				return;
			end
		end
	endfunction

	function automatic rsp_t predict(req_t r);
		rsp_t e;
		int slot;
		e = '0;
		case (r.func)
			FUNC_PUT: store(r.key, r.value_in);
			FUNC_GET: begin
				slot = find_key(r.key);
				if (slot >= 0) begin
					e.found     = 1'b1;
					e.value_out = shadow_value[slot];
					promote(slot);
				end
			end
			FUNC_EXISTS: e.found = (find_key(r.key) >= 0);
			default: ;
		endcase
		e.count = COUNT_WIDTH'(shadow_count);
		return e;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		if (!arst_n) begin
			for (int i = 0; i < DEPTH; i++) begin
				shadow_valid[i] = 1'b0;
				shadow_rank[i]  = 0;
			end
			shadow_count = 0;
			capacity     = CAP_RESET;
			expected_q.delete();
			n_fail    = 0;
			n_checked = 0;
			n_hits    = 0;
		end else begin
			if (psel && penable && pwrite && pready && paddr == REG_CAPACITY)
				capacity = pwdata[CAP_WIDTH-1:0];
			if (rsp_valid && rsp_ready) begin
				if (expected_q.size() == 0) begin
					n_fail++;
					$display("%0t: unexpected response: found %0b value %h count %0d",
						$time, rsp.found, rsp.value_out, rsp.count);
				end else begin
					want = expected_q.pop_front();
					if (rsp.found !== want.found) begin
						n_fail++;
						$display("%0t: found mismatch: expected %0b actual %0b",
							$time, want.found, rsp.found);
					end
					if (rsp.value_out !== want.value_out) begin
						n_fail++;
						$display("%0t: value_out mismatch: expected %h actual %h",
							$time, want.value_out, rsp.value_out);
					end
					if (rsp.count !== want.count) begin
						n_fail++;
						$display("%0t: count mismatch: expected %0d actual %0d",
							$time, want.count, rsp.count);
					end
					n_checked++;
				end
			end
			if (req_valid && req_ready) begin
				want = predict(req);
				if (want.found) n_hits++;
				expected_q.push_back(want);
			end
		end
		mismatch_count    <= n_fail;
		outstanding       <= expected_q.size();
		responses_checked <= n_checked;
		hits_seen         <= n_hits;
	end

endmodule
`default_nettype wire

>>> bench/tb_lru_key_value_cache_core.sv
// Top of the LRU key-value cache bench: clock, reset, request and capacity stimulus, verdict.
`timescale 1ns / 1ps
`default_nettype none
module tb_lru_key_value_cache_core
	import lkvc_pkg::*;
();

	localparam logic [FUNC_WIDTH-1:0] FUNC_RESERVED = 2'd3;
	localparam int PHASES          = 6;
	localparam int PHASE_ITEMS     = 145;
	localparam int POOL_SIZE       = 24;
	localparam int HOT_KEYS        = 8;
	localparam int WATCHDOG_LIMIT  = 5000;

	logic                      clk       = 1'b0;
	logic                      arst_n    = 1'b0;
	logic                      psel      = 1'b0;
	logic                      penable   = 1'b0;
	logic                      pwrite    = 1'b0;
	logic [APB_ADDR_WIDTH-1:0] paddr     = '0;
	logic [APB_DATA_WIDTH-1:0] pwdata    = '0;
	logic [APB_DATA_WIDTH-1:0] prdata;
	logic                      pready;
	logic                      req_valid = 1'b0;
	logic                      req_ready;
	req_t                      req       = '0;
	logic                      rsp_valid;
	logic                      rsp_ready = 1'b0;
	rsp_t                      rsp;

	int mismatch_count;
	int outstanding;
	int responses_checked;
	int hits_seen;
	int snd_idle     = 0;
	int rcv_stall    = 0;
	int quiet_cycles = 0;
	int cap_writes   = 0;

	logic [KEY_WIDTH-1:0] key_pool [POOL_SIZE];
	int snd_tab [PHASES] = '{0, 87, 0, 18, 0, 18};
	int rcv_tab [PHASES] = '{0, 0, 87, 18, 0, 18};
	int cap_tab [PHASES];

	lru_key_value_cache_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	lkvc_cache_checker u_checker (
		.clk               (clk),
		.arst_n            (arst_n),
		.psel              (psel),
		.penable           (penable),
		.pwrite            (pwrite),
		.pready            (pready),
		.paddr             (paddr),
		.pwdata            (pwdata),
		.req_valid         (req_valid),
		.req_ready         (req_ready),
		.req               (req),
		.rsp_valid         (rsp_valid),
		.rsp_ready         (rsp_ready),
		.rsp               (rsp),
		.mismatch_count    (mismatch_count),
		.outstanding       (outstanding),
		.responses_checked (responses_checked),
		.hits_seen         (hits_seen)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		rsp_ready <= ($urandom_range(99) >= rcv_stall);
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quiet_cycles <= 0;
		end else if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (psel && penable)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clk);
		$display("%0t: no handshake for %0d cycles, %0d responses still due",
			$time, WATCHDOG_LIMIT, outstanding);
		$display("CHECK FAILED");
		$finish;
	end

	task automatic send_item(input req_t item);
		if ($urandom_range(99) < snd_idle) begin
			req_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < snd_idle);
		end
		req_valid <= 1'b1;
		req       <= item;
		@(posedge clk);
		while (!req_ready) @(posedge clk);
	endtask

	task automatic drain();
		req_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	task automatic write_capacity(input int unsigned cap_val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= REG_CAPACITY;
		pwdata  <= APB_DATA_WIDTH'(cap_val);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		cap_writes++;
	endtask

	function automatic req_t random_request();
		req_t r;
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 45)      r.func = FUNC_PUT;
		else if (pick < 75) r.func = FUNC_GET;
		else if (pick < 95) r.func = FUNC_EXISTS;
		else                r.func = FUNC_RESERVED;
		pick = $urandom_range(99);
		if (pick < 60)      r.key = key_pool[$urandom_range(HOT_KEYS - 1)];
		else if (pick < 90) r.key = key_pool[$urandom_range(POOL_SIZE - 1)];
		else                r.key = $urandom();
		r.value_in = $urandom();
		return r;
	endfunction

	initial begin
		key_pool[0] = '0;
		key_pool[1] = '1;
		for (int i = 2; i < POOL_SIZE; i++) key_pool[i] = $urandom();
		cap_tab = '{16, 1, 0, 31, $urandom_range(15, 2), 4};

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_item(req_t'{FUNC_PUT, 32'h0000_0000, 32'h0000_0000});
		send_item(req_t'{FUNC_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF});
		send_item(req_t'{FUNC_GET, 32'h0000_0000, 32'hFFFF_FFFF});
		send_item(req_t'{FUNC_GET, 32'hFFFF_FFFF, 32'h0000_0000});
		send_item(req_t'{FUNC_EXISTS, 32'h0000_0000, 32'h1234_5678});
		send_item(req_t'{FUNC_EXISTS, 32'h0000_0005, 32'h0000_0000});
		send_item(req_t'{FUNC_GET, 32'h0000_0005, 32'h0000_0000});
		send_item(req_t'{FUNC_RESERVED, 32'h0000_0000, 32'hFFFF_FFFF});
		send_item(req_t'{FUNC_PUT, 32'h0000_0000, 32'hA5A5_A5A5});
		send_item(req_t'{FUNC_GET, 32'h0000_0000, 32'h0000_0000});
		for (int k = 1; k <= 14; k++) send_item(req_t'{FUNC_PUT, KEY_WIDTH'(k), $urandom()});
		send_item(req_t'{FUNC_PUT, 32'h0000_0100, 32'h5A5A_5A5A});
		send_item(req_t'{FUNC_GET, 32'hFFFF_FFFF, 32'h0000_0000});

		for (int p = 0; p < PHASES; p++) begin
			drain();
			snd_idle  <= snd_tab[p];
			rcv_stall <= rcv_tab[p];
			write_capacity(cap_tab[p]);
			for (int n = 0; n < PHASE_ITEMS; n++) send_item(random_request());
		end

		drain();
		repeat (4) @(posedge clk);
		$display("Summary: %0d responses compared, %0d lookups found their key, %0d capacity writes",
			responses_checked, hits_seen, cap_writes);
		$display("Capacities 0, 1, 16 and 31 visited, with and without idling on both channels");
		if (mismatch_count == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
`default_nettype wire

>>> sim.f
design/lkvc_pkg.sv
design/lkvc_ram.sv
design/lkvc_tags.sv
design/lru_key_value_cache_core.sv
design/lkvc_checker.sv
bench/lkvc_cache_checker.sv
bench/tb_lru_key_value_cache_core.sv
